// ===== rtl/plucked_string_voice_macros.svh =====
// Assertion macros for the plucked string voice.
// No dependencies; included by the top level only.
`ifndef PLUCKED_STRING_VOICE_MACROS_SVH
`define PLUCKED_STRING_VOICE_MACROS_SVH
`ifndef SYNTH
`define PSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("plucked_string_voice: assertion failed");
`define PSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plucked_string_voice: assertion failed");
`else
`define PSV_ASSERT(label, prop)
`define PSV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/psv_pkg.sv =====
// Shared constants, types and helpers of the plucked string voice.
// No dependencies; used by psv_ctrl, psv_datapath and the top level.
package psv_pkg;

  localparam int unsigned DELAY_DEPTH_DEF = 1024;
  localparam int unsigned DATA_W          = 16;
  localparam int unsigned STRENGTH_W      = 15;
  localparam int unsigned DLEN_W          = 11;
  localparam int unsigned LFSR_W          = 32;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED   = 1'b1;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PLUCK = 1'b1;

  localparam logic [DLEN_W-1:0]     DLEN_RST     = 11'd100;
  localparam logic [LFSR_W-1:0]     LFSR_RST     = 32'd1;
  localparam logic [LFSR_W-1:0]     LFSR_MASK    = 32'hA300_0000;
  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 15'd8192;
  localparam logic signed [DATA_W:0] SAT_POS     = 17'sd32767;
  localparam logic signed [DATA_W:0] SAT_NEG     = -17'sd32767;

  // controller -> datapath
  typedef struct packed {
    logic accept_tick;
    logic accept_pluck;
    logic tick_commit;
    logic clear_en;
    logic pluck_issue;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic pluck_last;
    logic pipe_busy;
  } stat_t;

  // right-shift Galois step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_MASK;
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_q15(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] r;
    r = v;
    if (v > SAT_POS) begin
      r = SAT_POS;
    end else if (v < SAT_NEG) begin
      r = SAT_NEG;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/plucked_string_voice.sv =====
// Top level of the plucked string voice (Karplus-Strong string).
// Depends on psv_pkg, psv_ctrl, psv_datapath and plucked_string_voice_macros.svh.
//
//   port group    handshake                   word
//   input         in_valid_i / in_ready_o     mode_i, mix_in_i, strength_i
//   output        out_valid_o / out_ready_i   sample_out_o
//   config        cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// After reset all DELAY_DEPTH entries of the delay memory are swept to zero, one
// entry a cycle, with in_ready_o low; config writes are taken during the sweep.
// A tick reads the memory at the accept edge; once the output slot is free, it
// writes the filtered word back and loads the output register.
// A tick waits in place while the output register still holds an untaken word.
// A pluck walks the effective length: one entry enters the three-stage read /
// multiply / write pipeline per cycle, then it drains.
`include "plucked_string_voice_macros.svh"

module plucked_string_voice #(
  parameter int unsigned DELAY_DEPTH = psv_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input words
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   mode_i,
  input  logic signed [psv_pkg::DATA_W-1:0]      mix_in_i,
  input  logic        [psv_pkg::STRENGTH_W-1:0]  strength_i,
  // output words
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [psv_pkg::DATA_W-1:0]      sample_out_o,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic        [psv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic        [psv_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import psv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the handshakes and the output valid flag
  psv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // delay memory, recirculation filter, noise LFSR and config registers
  psv_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mix_in_i     (mix_in_i),
    .strength_i   (strength_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_out_o (sample_out_o)
  );

  // no input is taken while the clear sweep or pluck writes are pending
  `PSV_ASSERT(a_clear_blocks_input, cmd.clear_en |-> !in_ready_o)
  `PSV_ASSERT(a_pipe_blocks_input, stat.pipe_busy |-> !in_ready_o)
  // at most one memory writer is commanded at a time
  `PSV_ASSERT(a_one_writer, $countones({cmd.clear_en, cmd.tick_commit, cmd.pluck_issue}) <= 1)
  // a committed tick always shows up at the output
  `PSV_ASSERT_NEXT(a_commit_shows, cmd.tick_commit, out_valid_o)

endmodule

// ===== rtl/psv_ctrl.sv =====
// Sequencer of the plucked string voice: clear sweep, tick, pluck walk.
// Depends on psv_pkg; drives psv_datapath through cmd_t / stat_t.
module psv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psv_pkg::cmd_t   cmd_o,
  input  psv_pkg::stat_t  stat_i
);
  import psv_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_TICK  = 5'b00100,
    ST_PLUCK = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_PLUCK) begin
            cmd_o.accept_pluck = 1'b1;
            state_d            = ST_PLUCK;
          end else begin
            cmd_o.accept_tick = 1'b1;
            state_d           = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.tick_commit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_PLUCK: begin
        cmd_o.pluck_issue = 1'b1;
        if (stat_i.pluck_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.tick_commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/psv_datapath.sv =====
// Datapath of the plucked string voice: delay memory, filter, noise pipeline.
// Depends on psv_pkg; commanded by psv_ctrl.
module psv_datapath #(
  parameter int unsigned DELAY_DEPTH = psv_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  psv_pkg::cmd_t                           cmd_i,
  output psv_pkg::stat_t                          stat_o,
  input  logic signed [psv_pkg::DATA_W-1:0]       mix_in_i,
  input  logic        [psv_pkg::STRENGTH_W-1:0]   strength_i,
  input  logic                                    cfg_we_i,
  input  logic        [psv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic        [psv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic signed [psv_pkg::DATA_W-1:0]       sample_out_o
);
  import psv_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned LW = (AW + 1 > DLEN_W) ? AW + 1 : DLEN_W;
  localparam int unsigned SW = 14;  // clamped strength, up to 8192
  localparam int unsigned PW = SW + 1 + DATA_W;
  localparam logic [LW-1:0] LEN_MIN  = LW'(2);
  localparam logic [LW-1:0] LEN_MAX  = LW'(DELAY_DEPTH);
  localparam logic [AW-1:0] ADDR_TOP = AW'(DELAY_DEPTH - 1);

  // configuration
  logic [DLEN_W-1:0] dlen_q;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d, lfsr_nxt;
  logic [LW-1:0]     len;

  // tick state
  logic        [AW-1:0]     pos_q, pos_d;
  logic        [LW-1:0]     pos_inc;
  logic signed [DATA_W-1:0] prev_q;
  logic signed [DATA_W-1:0] mix_q;
  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W:0]   avg_sum;
  logic signed [DATA_W:0]   mix_sum;

  // walk index and noise pipeline
  logic        [AW-1:0]     idx_q, idx_d;
  logic        [SW-1:0]     str_q;
  logic                     v1_q, v2_q;
  logic        [AW-1:0]     a1_q, a2_q;
  logic signed [DATA_W-1:0] n_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [DATA_W-1:0] old_q;
  logic signed [DATA_W-1:0] add_v;
  logic signed [DATA_W:0]   pl_sum;

  // memory
  logic signed [DATA_W-1:0] mem [DELAY_DEPTH];
  logic signed [DATA_W-1:0] rd_q;
  logic                     re, we;
  logic        [AW-1:0]     ra, wa;
  logic signed [DATA_W-1:0] wd;

  always_comb begin
    len = LW'(dlen_q);
    if (len < LEN_MIN) begin
      len = LEN_MIN;
    end else if (len > LEN_MAX) begin
      len = LEN_MAX;
    end
  end

  assign stat_o.clear_last = (idx_q == ADDR_TOP);
  assign stat_o.pluck_last = (LW'(idx_q) == len - LW'(1));
  assign stat_o.pipe_busy  = v1_q | v2_q;

  // tick arithmetic on the registered read word
  assign avg_sum = {rd_q[DATA_W-1], rd_q} + {prev_q[DATA_W-1], prev_q};
  assign mix_sum = {rd_q[DATA_W-1], rd_q} + {mix_q[DATA_W-1], mix_q};
  assign pos_inc = LW'(pos_q) + LW'(1);
  assign pos_d   = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];

  // floor(strength * n / 32768)
  assign add_v  = prod_q[PW-1:PW-DATA_W];
  assign pl_sum = {old_q[DATA_W-1], old_q} + {add_v[DATA_W-1], add_v};

  assign lfsr_nxt = lfsr_step(lfsr_q);

  always_comb begin
    lfsr_d = lfsr_q;
    if (cfg_we_i && cfg_idx_i == CFG_NOISE_SEED) begin
      lfsr_d = (cfg_data_i == '0) ? LFSR_RST : cfg_data_i[LFSR_W-1:0];
    end else if (cmd_i.pluck_issue) begin
      lfsr_d = lfsr_nxt;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept_pluck || (cmd_i.clear_en && stat_o.clear_last)) begin
      idx_d = '0;
    end else if (cmd_i.clear_en || cmd_i.pluck_issue) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    re = cmd_i.accept_tick | cmd_i.pluck_issue;
    ra = cmd_i.accept_tick ? pos_q : idx_q;
    we = 1'b0;
    wa = idx_q;
    wd = '0;
    priority if (cmd_i.clear_en) begin
      we = 1'b1;
    end else if (cmd_i.tick_commit) begin
      we = 1'b1;
      wa = pos_q;
      wd = avg_sum[DATA_W:1];
    end else if (v2_q) begin
      we = 1'b1;
      wa = a2_q;
      wd = sat_q15(pl_sum);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q <= DLEN_RST;
      lfsr_q <= LFSR_RST;
      pos_q  <= '0;
      prev_q <= '0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_DELAY_LENGTH) begin
        dlen_q <= cfg_data_i[DLEN_W-1:0];
      end
      lfsr_q <= lfsr_d;
      idx_q  <= idx_d;
      v1_q   <= cmd_i.pluck_issue;
      v2_q   <= v1_q;
      if (cmd_i.tick_commit) begin
        pos_q  <= pos_d;
        prev_q <= rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_tick) begin
      mix_q <= mix_in_i;
    end
    if (cmd_i.accept_pluck) begin
      str_q <= (strength_i > STRENGTH_MAX) ? STRENGTH_MAX[SW-1:0] : strength_i[SW-1:0];
    end
    if (cmd_i.tick_commit) begin
      sample_q <= sat_q15(mix_sum);
    end
    a1_q   <= idx_q;
    n_q    <= lfsr_nxt[LFSR_W-1:LFSR_W-DATA_W];
    a2_q   <= a1_q;
    old_q  <= rd_q;
    prod_q <= $signed({1'b0, str_q}) * n_q;
  end

  assign sample_out_o = sample_q;

endmodule
